[design/obst_pkg.sv]
`timescale 1ns / 1ps

package obst_pkg;

    // Field widths fixed by the stream format
    localparam int KEY_W    = 4;
    localparam int WEIGHT_W = 16;
    localparam int COST_W   = 24;
    localparam int ADDR_W   = 2 * KEY_W;

    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

    typedef logic [KEY_W-1:0]  t_key;
    typedef logic [COST_W-1:0] t_cost;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_we;   // store incoming weight at load_idx
        t_key load_idx;
        logic init;      // clear accumulators for a new interval
        logic eval;      // fold in candidate root r
        logic write;     // write interval cost, capture result
        t_key s;         // interval start
        t_key e;         // interval end
        t_key r;         // candidate root
        logic last;      // interval spans the whole key range
    } t_dp_cmd;

    // Saturating add of two costs
    function automatic t_cost sat_add(input t_cost a, input t_cost b);
        logic [COST_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[COST_W] ? COST_MAX : sum[COST_W-1:0];
    endfunction

endpackage

[design/obst_ram.sv]
`timescale 1ns / 1ps

module obst_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    output logic [WIDTH-1:0] o_rdata_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    // One write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

[design/obst_ctrl.sv]
`timescale 1ns / 1ps

module obst_ctrl
    import obst_pkg::*;
#(
    parameter int MAX_KEYS = 8
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_last,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_INIT  = 3'd1;
    localparam logic [2:0] S_ISSUE = 3'd2;
    localparam logic [2:0] S_EVAL  = 3'd3;
    localparam logic [2:0] S_WRITE = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    localparam t_key KEYS = KEY_W'(MAX_KEYS);

    logic [2:0] r_state, n_state;
    t_key       r_cnt, n_cnt;   // keys loaded
    t_key       r_n, n_n;       // keys in the set being computed
    t_key       r_s, n_s;
    t_key       r_e, n_e;
    t_key       r_d, n_d;       // interval length minus one
    t_key       r_r, n_r;
    logic       w_full;

    assign w_full      = (r_cnt == KEYS);
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    // Sequencer over diagonals, starts and candidate roots
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_n     = r_n;
        n_s     = r_s;
        n_e     = r_e;
        n_d     = r_d;
        n_r     = r_r;

        o_cmd          = '0;
        o_cmd.load_idx = r_cnt;
        o_cmd.s        = r_s;
        o_cmd.e        = r_e;
        o_cmd.r        = r_r;
        o_cmd.last     = (r_d + 1'b1 == r_n);

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (!w_full) begin
                        o_cmd.load_we = 1'b1;
                        n_cnt         = r_cnt + 1'b1;
                    end
                    if (i_in_last) begin
                        n_n     = w_full ? r_cnt : r_cnt + 1'b1;
                        n_s     = '0;
                        n_e     = '0;
                        n_d     = '0;
                        n_state = S_INIT;
                    end
                end
            end
            S_INIT: begin
                o_cmd.init = 1'b1;
                n_r        = r_s;
                n_state    = S_ISSUE;
            end
            S_ISSUE: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                if (r_r == r_e) begin
                    n_state = S_WRITE;
                end else begin
                    n_r     = r_r + 1'b1;
                    n_state = S_ISSUE;
                end
            end
            S_WRITE: begin
                o_cmd.write = 1'b1;
                n_state     = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    if (r_e + 1'b1 < r_n) begin
                        n_s     = r_s + 1'b1;
                        n_e     = r_e + 1'b1;
                        n_state = S_INIT;
                    end else if (r_d + 1'b1 < r_n) begin
                        n_d     = r_d + 1'b1;
                        n_s     = '0;
                        n_e     = r_d + 1'b1;
                        n_state = S_INIT;
                    end else begin
                        n_cnt   = '0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_n     <= '0;
            r_s     <= '0;
            r_e     <= '0;
            r_d     <= '0;
            r_r     <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_n     <= n_n;
            r_s     <= n_s;
            r_e     <= n_e;
            r_d     <= n_d;
            r_r     <= n_r;
        end
    end

endmodule

[design/obst_dp.sv]
`timescale 1ns / 1ps

module obst_dp
    import obst_pkg::*;
#(
    parameter int MAX_KEYS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    input  logic [WEIGHT_W-1:0] i_weight,
    output t_key                o_start,
    output t_key                o_end,
    output t_cost               o_cost,
    output t_key                o_root,
    output logic                o_last
);

    localparam int DEPTH = MAX_KEYS * MAX_KEYS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW    = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam logic [ADDR_W-1:0] ROW = ADDR_W'(MAX_KEYS);

    logic [WEIGHT_W-1:0] r_weight [MAX_KEYS];

    t_cost r_total;
    t_cost r_best;
    t_key  r_root;
    logic  r_have;

    t_key  r_o_start;
    t_key  r_o_end;
    t_cost r_o_cost;
    t_key  r_o_root;
    logic  r_o_last;

    logic              w_left_none;
    logic              w_right_none;
    logic [ADDR_W-1:0] w_waddr;
    logic [ADDR_W-1:0] w_laddr;
    logic [ADDR_W-1:0] w_raddr;
    t_cost             w_left_rd;
    t_cost             w_right_rd;
    t_cost             w_cand;
    t_cost             w_final;

    assign w_left_none  = (i_cmd.r == i_cmd.s);
    assign w_right_none = (i_cmd.r == i_cmd.e);

    // Table addresses: row = start key, column = end key
    assign w_waddr = {{KEY_W{1'b0}}, i_cmd.s} * ROW + {{KEY_W{1'b0}}, i_cmd.e};
    assign w_laddr = w_left_none ? '0 :
                     {{KEY_W{1'b0}}, i_cmd.s} * ROW
                     + {{KEY_W{1'b0}}, KEY_W'(i_cmd.r - 1'b1)};
    assign w_raddr = w_right_none ? '0 :
                     {{KEY_W{1'b0}}, KEY_W'(i_cmd.r + 1'b1)} * ROW
                     + {{KEY_W{1'b0}}, i_cmd.e};

    obst_ram #(
        .WIDTH (COST_W),
        .DEPTH (DEPTH)
    ) u_cost_ram (
        .i_clk     (i_clk),
        .i_we      (i_cmd.write),
        .i_waddr   (w_waddr[AW-1:0]),
        .i_wdata   (w_final),
        .i_raddr_a (w_laddr[AW-1:0]),
        .o_rdata_a (w_left_rd),
        .i_raddr_b (w_raddr[AW-1:0]),
        .o_rdata_b (w_right_rd)
    );

    // Empty subtrees cost nothing
    assign w_cand  = sat_add(w_left_none  ? '0 : w_left_rd,
                             w_right_none ? '0 : w_right_rd);
    assign w_final = sat_add(r_total, r_best);

    // Weight store
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_we) begin
            r_weight[i_cmd.load_idx[IW-1:0]] <= i_weight;
        end
    end

    // Root search: running weight sum and first minimum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
        end else if (i_cmd.init) begin
            r_have <= 1'b0;
        end else if (i_cmd.eval) begin
            r_have <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_total <= '0;
        end else if (i_cmd.eval) begin
            r_total <= sat_add(r_total,
                               {{(COST_W-WEIGHT_W){1'b0}}, r_weight[i_cmd.r[IW-1:0]]});
            if (!r_have || w_cand < r_best) begin
                r_best <= w_cand;
                r_root <= i_cmd.r;
            end
        end
    end

    // Result register, held until the output transfer
    always_ff @(posedge i_clk) begin
        if (i_cmd.write) begin
            r_o_start <= i_cmd.s;
            r_o_end   <= i_cmd.e;
            r_o_cost  <= w_final;
            r_o_root  <= r_root;
            r_o_last  <= i_cmd.last;
        end
    end

    assign o_start = r_o_start;
    assign o_end   = r_o_end;
    assign o_cost  = r_o_cost;
    assign o_root  = r_o_root;
    assign o_last  = r_o_last;

endmodule

[design/optimal_bst_cost_table.sv]
`timescale 1ns / 1ps

// Optimal binary search tree cost table. Key weights (Q0.16) arrive one per
// transfer on the slave side, one per cycle, in key order; tlast marks the last
// key and starts the fill. At most MAX_KEYS keys are kept, later weights of a
// set are dropped. After the marked key the block takes no input until the
// whole set is out: each interval runs a setup step, then, for each candidate
// root, a read of both subtree costs from the cost RAM and a compare, then
// write-back and the output transfer. Results come out by interval length,
// then by rising start, tlast on the whole key range. Costs saturate at
// 2^24-1; ties pick the lowest root. The cost RAM holds no reset state.
module optimal_bst_cost_table
    import obst_pkg::*;
#(
    parameter int MAX_KEYS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] weight
    input  logic        s_axis_tlast,   // final_key
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [3:0] interval_start, [7:4] interval_end,
                                        // [31:8] subtree_cost, [35:32] subtree_root
    output logic        m_axis_tlast    // last_result
);

    t_dp_cmd w_cmd;
    t_key    w_start;
    t_key    w_end;
    t_cost   w_cost;
    t_key    w_root;

    obst_ctrl #(
        .MAX_KEYS (MAX_KEYS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_last   (s_axis_tlast),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (w_cmd)
    );

    obst_dp #(
        .MAX_KEYS (MAX_KEYS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_weight (s_axis_tdata),
        .o_start  (w_start),
        .o_end    (w_end),
        .o_cost   (w_cost),
        .o_root   (w_root),
        .o_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {4'b0000, w_root, w_cost, w_end, w_start};

endmodule

[design/obst_checker.sv]
`timescale 1ns / 1ps

module obst_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // No key is taken while a result is pending
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while result pending");

    // A marked key closes the input until the set is out
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input open after marked key");

    // The final result reopens the input
    a_reopen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready)
        else $error("input not reopened after final result");

    // Interval start never past its end
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[3:0] <= m_axis_tdata[7:4])
        else $error("interval start past end");

endmodule

bind optimal_bst_cost_table obst_checker u_obst_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

[tb/optimal_bst_cost_table_tb.sv]
`timescale 1ns / 1ps

module optimal_bst_cost_table_tb;
    import obst_pkg::*;

    localparam int NUM_KEYS    = 8;
    localparam int TOTAL_KEYS  = 430;
    localparam int HOLD_CYCLES = 600;
    localparam int DRAIN       = 400;
    localparam int LIMIT       = 500000;

    // One interval result as it leaves the master side
    typedef struct {
        t_key  first_key;
        t_key  last_key;
        t_cost cost;
        t_key  root;
        logic  whole_range;
    } t_interval;

    // Tracks the loaded keys, fills the cost/root tables on a marked key and
    // queues the interval results in the order the block emits them.
    class interval_cost_checker;
        logic [WEIGHT_W-1:0] key_weight[NUM_KEYS];
        t_cost cost_of[NUM_KEYS][NUM_KEYS];
        t_key  root_of[NUM_KEYS][NUM_KEYS];
        int keys_held;
        t_interval expected_intervals[$];
        int mismatches;

        function new();
            keys_held  = 0;
            mismatches = 0;
        endfunction

        task report(string msg);
            $display("ERROR @%0t: %s", $realtime, msg);
            mismatches++;
        endtask

        // Saturating cost addition
        function t_cost add_costs(t_cost a, t_cost b);
            logic [COST_W:0] sum;
            sum = {1'b0, a} + {1'b0, b};
            return sum[COST_W] ? COST_MAX : sum[COST_W-1:0];
        endfunction

        function void take_key(logic [WEIGHT_W-1:0] w, logic marked);
            int n;
            int e;
            t_cost total;
            t_cost best;
            t_cost cand;
            t_cost lc;
            t_cost rc;
            t_key best_root;
            t_interval item;
            // weights past the table depth are dropped
            if (keys_held < NUM_KEYS) begin
                key_weight[keys_held] = w;
                keys_held++;
            end
            if (!marked) return;
            n = keys_held;
            // fill by diagonal, rising start within a diagonal
            for (int d = 0; d < n; d++) begin
                for (int s = 0; s + d < n; s++) begin
                    e = s + d;
                    total = '0;
                    for (int r = s; r <= e; r++)
                        total = add_costs(total, t_cost'(key_weight[r]));
                    best = '0;
                    best_root = t_key'(s);
                    for (int r = s; r <= e; r++) begin
                        lc = (r == s) ? t_cost'(0) : cost_of[s][r-1];
                        rc = (r == e) ? t_cost'(0) : cost_of[r+1][e];
                        cand = add_costs(lc, rc);
                        // strict compare keeps the first minimum
                        if (r == s || cand < best) begin
                            best = cand;
                            best_root = t_key'(r);
                        end
                    end
                    cost_of[s][e] = add_costs(total, best);
                    root_of[s][e] = best_root;
                    item.first_key   = t_key'(s);
                    item.last_key    = t_key'(e);
                    item.cost        = cost_of[s][e];
                    item.root        = best_root;
                    item.whole_range = (d + 1 == n);
                    expected_intervals.push_back(item);
                end
            end
            keys_held = 0;
        endfunction

        task check_interval(t_key first_key, t_key last_key, t_cost cost, t_key root,
                            logic whole_range);
            t_interval exp_item;
            if (expected_intervals.size() == 0) begin
                report($sformatf("unexpected result [%0d..%0d] cost %0d root %0d",
                                 first_key, last_key, cost, root));
                return;
            end
            exp_item = expected_intervals.pop_front();
            if (first_key !== exp_item.first_key)
                report($sformatf("interval_start %0d, want %0d",
                                 first_key, exp_item.first_key));
            if (last_key !== exp_item.last_key)
                report($sformatf("interval_end %0d, want %0d",
                                 last_key, exp_item.last_key));
            if (cost !== exp_item.cost)
                report($sformatf("[%0d..%0d] subtree_cost %0d, want %0d",
                                 exp_item.first_key, exp_item.last_key, cost, exp_item.cost));
            if (root !== exp_item.root)
                report($sformatf("[%0d..%0d] subtree_root %0d, want %0d",
                                 exp_item.first_key, exp_item.last_key, root, exp_item.root));
            if (whole_range !== exp_item.whole_range)
                report($sformatf("[%0d..%0d] last_result %0b, want %0b",
                                 exp_item.first_key, exp_item.last_key, whole_range,
                                 exp_item.whole_range));
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;     // [15:0] weight
    logic        s_axis_tlast = 1'b0;   // final_key
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;          // [3:0] start, [7:4] end, [31:8] cost, [35:32] root
    logic        m_axis_tlast;          // last_result

    interval_cost_checker sb;

    int phase = 0;
    int sender_idle_pct = 9;
    int recv_idle_pct = 71;
    int keys_sent = 0;
    int hold_left = 0;
    logic hold_done = 1'b0;
    int cycles = 0;

    optimal_bst_cost_table #(
        .MAX_KEYS(NUM_KEYS)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off when the last phase starts
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (phase == 2 && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_interval(m_axis_tdata[3:0], m_axis_tdata[7:4], m_axis_tdata[31:8],
                              m_axis_tdata[35:32], m_axis_tlast);
    end

    // Offer one key; returns after the transfer
    task send_key(logic [15:0] w, logic marked);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        s_axis_tlast  <= marked;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.take_key(w, marked);
        keys_sent++;
    endtask

    task send_set(int count, logic [15:0] w);
        for (int k = 0; k < count; k++)
            send_key(w, k == count - 1);
    endtask

    // Weights biased toward extremes and small values for ties
    function logic [15:0] pick_weight();
        case ($urandom_range(3))
            0: return 16'($urandom_range(255));
            1: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        int set_len;
        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: single keys at both extremes
        send_key(16'h0000, 1'b1);
        send_key(16'hFFFF, 1'b1);
        // full table of largest weights, marked on the last slot
        send_set(NUM_KEYS, 16'hFFFF);
        // all-zero keys: every root ties
        send_set(3, 16'h0000);
        // oversize set: unmarked and marked weights past the depth are dropped
        for (int k = 0; k < 10; k++)
            send_key(16'h1000 + 16'(k * 16'h0111), k == 9);

        // Random sets across three idle profiles
        while (keys_sent < TOTAL_KEYS) begin
            if (keys_sent >= 300 && phase != 2) begin
                phase = 2;
                sender_idle_pct = 0;
                recv_idle_pct = 0;
            end else if (keys_sent >= 165 && phase == 0) begin
                phase = 1;
                sender_idle_pct = 71;
                recv_idle_pct = 9;
            end
            set_len = ($urandom_range(9) == 0) ? $urandom_range(10, 9) : $urandom_range(8, 1);
            for (int k = 0; k < set_len; k++)
                send_key(pick_weight(), k == set_len - 1);
        end
        s_axis_tvalid <= 1'b0;

        while (sb.expected_intervals.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        if (sb.mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
